// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each is empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ===== hdl/rsb_pkg.sv =====
package rsb_pkg;

	localparam int SPRITE_SIDE = 128;
	localparam int SIDE_W      = $clog2(SPRITE_SIDE);
	localparam int STORE_DEPTH = SPRITE_SIDE * SPRITE_SIDE;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIN_VAL      = 3'd0,
		REG_COS_VAL      = 3'd1,
		REG_DST_PIVOT_X  = 3'd2,
		REG_DST_PIVOT_Y  = 3'd3,
		REG_ORG_X        = 3'd4,
		REG_ORG_Y        = 3'd5,
		REG_USED_W       = 3'd6,
		REG_USED_H       = 3'd7
	} cfg_reg_t;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [6:0]  load_col;
		logic [6:0]  load_row;
		logic [31:0] load_pixel;
		logic [10:0] dst_x;
		logic [10:0] dst_y;
	} req_t;

	typedef struct packed {
		logic        write_enable;
		logic [10:0] out_x;
		logic [10:0] out_y;
		logic [31:0] out_pixel;
	} res_t;

	typedef struct packed {
		logic signed [17:0] sin_val;
		logic signed [17:0] cos_val;
		logic signed [12:0] dst_pivot_x;
		logic signed [12:0] dst_pivot_y;
		logic signed [10:0] org_x;
		logic signed [10:0] org_y;
		logic [7:0]         used_w;
		logic [7:0]         used_h;
	} cfg_t;

	// Transform result handed to the store stage.
	typedef struct packed {
		logic               valid;
		req_t               req;
		logic signed [17:0] sx;
		logic signed [17:0] sy;
	} xf_t;

	// Store lookup result handed to the output register.
	typedef struct packed {
		logic        valid;
		logic        hit;
		logic [10:0] x;
		logic [10:0] y;
		logic [31:0] texel;
	} st_t;

endpackage

// ===== hdl/rsb_xform.sv =====
module rsb_xform
	import rsb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  req_t in_data,
	input  cfg_t cfg,
	output xf_t  xf
);

	logic               v_s1, v_s2, v_s3;
	req_t               req_s1, req_s2, req_s3;
	logic signed [13:0] rx_s1, ry_s1;
	logic signed [31:0] rxc_s2, rys_s2, ryc_s2, rxs_s2;
	logic signed [17:0] sx_s3, sy_s3;

	logic signed [13:0] rx_c, ry_c;
	logic signed [31:0] rxc_c, rys_c, ryc_c, rxs_c;
	logic signed [32:0] sum_x, sum_y;
	logic signed [17:0] sx_c, sy_c;

	assign rx_c = $signed({3'b000, in_data.dst_x}) - $signed({cfg.dst_pivot_x[12], cfg.dst_pivot_x});
	assign ry_c = $signed({3'b000, in_data.dst_y}) - $signed({cfg.dst_pivot_y[12], cfg.dst_pivot_y});

	assign rxc_c = rx_s1 * cfg.cos_val;
	assign rys_c = ry_s1 * cfg.sin_val;
	assign ryc_c = ry_s1 * cfg.cos_val;
	assign rxs_c = rx_s1 * cfg.sin_val;

	assign sum_x = $signed({rxc_s2[31], rxc_s2}) + $signed({rys_s2[31], rys_s2});
	assign sum_y = $signed({ryc_s2[31], ryc_s2}) - $signed({rxs_s2[31], rxs_s2});

	// Dropping the low 16 bits of a two's complement sum floors it.
	assign sx_c = $signed({{7{cfg.org_x[10]}}, cfg.org_x})
		+ $signed({sum_x[32], sum_x[32:16]});
	assign sy_c = $signed({{7{cfg.org_y[10]}}, cfg.org_y})
		+ $signed({sum_y[32], sum_y[32:16]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= in_data;
			rx_s1  <= rx_c;
			ry_s1  <= ry_c;
			req_s2 <= req_s1;
			rxc_s2 <= rxc_c;
			rys_s2 <= rys_c;
			ryc_s2 <= ryc_c;
			rxs_s2 <= rxs_c;
			req_s3 <= req_s2;
			sx_s3  <= sx_c;
			sy_s3  <= sy_c;
		end
	end

	assign xf = '{valid: v_s3, req: req_s3, sx: sx_s3, sy: sy_s3};

endmodule

// ===== hdl/rsb_store.sv =====
module rsb_store
	import rsb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  xf_t        xf,
	input  logic [7:0] used_w,
	input  logic [7:0] used_h,
	output st_t        st
);

	logic [31:0] mem [STORE_DEPTH];

	logic                v_s4, hit_s4;
	logic [10:0]         x_s4, y_s4;
	logic [31:0]         rd_s4;

	logic                is_pix, x_ok, y_ok, hit_c, ld_ok;
	logic [16:0]         sx_u, sy_u;
	logic [STORE_AW-1:0] rd_addr, ld_addr, addr;

	assign is_pix = (xf.req.req_type == REQ_PIXEL);
	assign sx_u   = xf.sx[16:0];
	assign sy_u   = xf.sy[16:0];

	assign x_ok = !xf.sx[17] && (sx_u < 17'(used_w)) && (sx_u < 17'(SPRITE_SIDE));
	assign y_ok = !xf.sy[17] && (sy_u < 17'(used_h)) && (sy_u < 17'(SPRITE_SIDE));
	assign hit_c = xf.valid && is_pix && x_ok && y_ok;

	assign ld_ok = (xf.req.load_col < SPRITE_SIDE) && (xf.req.load_row < SPRITE_SIDE);

	assign rd_addr = STORE_AW'(sy_u[SIDE_W-1:0] * SPRITE_SIDE + sx_u[SIDE_W-1:0]);
	assign ld_addr = STORE_AW'(xf.req.load_row * SPRITE_SIDE + xf.req.load_col);
	assign addr    = is_pix ? rd_addr : ld_addr;

	// Loads and lookups share one port in the same stage, so a lookup always
	// sees every load that came before it.
	always_ff @(posedge clk) begin
		if (adv && xf.valid && !is_pix && ld_ok) begin
			mem[addr] <= xf.req.load_pixel;
		end
		if (adv && hit_c) begin
			rd_s4 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4   <= 1'b0;
			hit_s4 <= 1'b0;
		end else if (adv) begin
			v_s4   <= xf.valid;
			hit_s4 <= hit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4 <= xf.req.dst_x;
			y_s4 <= xf.req.dst_y;
		end
	end

	assign st = '{valid: v_s4, hit: hit_s4, x: x_s4, y: y_s4, texel: rd_s4};

endmodule

// ===== hdl/rotated_sprite_blit_affine_core.sv =====
// Channel  | Direction | Valid     | Stall     | Payload
// ---------+-----------+-----------+-----------+-------------------------------
// request  | in        | in_valid  | in_stall  | in_data (req_t)
// result   | out       | out_valid | out_stall | out_data (res_t)
// config   | in        | cfg_we    | none      | cfg_index, cfg_data
//
// One beat is accepted per clock while in_stall is low; every request beat yields
// exactly one result beat, offered through five register stages: three transform
// stages, the store access with its registered read, and the output register.
// Reset clears the valid bits and loads the register defaults; the sprite store
// holds no reset value and is never cleared.
// A result beat held by out_stall freezes the whole pipeline, and in_stall rises
// in that same cycle; bubbles in the pipeline are not squeezed out.
`include "assert_macros.svh"

module rotated_sprite_blit_affine_core
	import rsb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  req_t                  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output res_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic out_valid_q;
	res_t out_data_q;
	logic adv;
	xf_t  xf;
	st_t  st;
	logic we_c;

	// The pipeline moves whenever the output register is empty or being taken.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// Register file. Software must write these only while the pipeline is empty; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sin_val     <= 18'sd0;
			cfg_q.cos_val     <= 18'sd65536;
			cfg_q.dst_pivot_x <= 13'sd0;
			cfg_q.dst_pivot_y <= 13'sd0;
			cfg_q.org_x       <= 11'sd0;
			cfg_q.org_y       <= 11'sd0;
			cfg_q.used_w      <= 8'd128;
			cfg_q.used_h      <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SIN_VAL:     cfg_q.sin_val     <= cfg_data;
				REG_COS_VAL:     cfg_q.cos_val     <= cfg_data;
				REG_DST_PIVOT_X: cfg_q.dst_pivot_x <= cfg_data[12:0];
				REG_DST_PIVOT_Y: cfg_q.dst_pivot_y <= cfg_data[12:0];
				REG_ORG_X:       cfg_q.org_x       <= cfg_data[10:0];
				REG_ORG_Y:       cfg_q.org_y       <= cfg_data[10:0];
				REG_USED_W:      cfg_q.used_w      <= cfg_data[7:0];
				REG_USED_H:      cfg_q.used_h      <= cfg_data[7:0];
			endcase
		end
	end

	// Pivot subtraction, rotation products, and sum, shift and anchor add.
	rsb_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.xf       (xf)
	);

	// Bounds check and the sprite store: loads write it, pixels read it.
	rsb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.xf     (xf),
		.used_w (cfg_q.used_w),
		.used_h (cfg_q.used_h),
		.st     (st)
	);

	// A zero texel is transparent; loads and misses give an all-zero beat.
	assign we_c = st.hit && (st.texel != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= st.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= we_c ? res_t'{write_enable: 1'b1, out_x: st.x, out_y: st.y,
				out_pixel: st.texel} : res_t'('0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ASSERT_IMPLIES(a_hit_opaque, clk, arst_n, out_valid && out_data.write_enable, out_data.out_pixel != 32'd0)
	`ASSERT_IMPLIES(a_miss_zero, clk, arst_n, out_valid && !out_data.write_enable, out_data == '0)
	`ASSERT_IMPLIES(a_stall_back, clk, arst_n, out_valid && out_stall, in_stall)
	`ASSERT_IMPLIES(a_no_false_stall, clk, arst_n, !out_valid, !in_stall)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

// Top level of the sprite blitter bench. Requests are queued in phases by the
// initial block below; a clocked driver presents them on the request channel and
// a clocked monitor takes result beats and compares them with the predicted
// writes. Each phase first programs every register while the pipe is empty.
module tb;
	import rsb_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	req_t                  in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	res_t                  out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SIN_VAL;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Requests waiting to be driven, and the result beats that accepted
	// requests will produce, oldest first.
	req_t req_backlog [$];
	res_t due_results [$];

	// The predictor's own copy of the sprite store and of the registers. The
	// generator separately tracks which texels it has already loaded, so that no
	// pixel beat ever reads a texel that was never written.
	logic [31:0] sprite_copy  [STORE_DEPTH];
	bit          texel_loaded [STORE_DEPTH];
	cfg_t        shadow;

	int mismatches = 0;
	int n_loads    = 0;
	int n_pixels   = 0;
	int n_writes   = 0;
	int n_settings = 0;

	// Idle control for both channels, switched per phase.
	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	int src_wait     = 0;
	int sink_wait    = 0;
	int next_hold;
	res_t want;

	rotated_sprite_blit_affine_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Inverse map of one destination pixel into the cropped sprite. The pivot is
	// subtracted, the offset is rotated by the programmed sine and cosine in
	// signed Q2.16, and the arithmetic shift floors toward minus infinity. Returns true
	// when the source point lies inside the used area and inside the store.
	function automatic bit src_point(input req_t r, output int col, output int row);
		longint rx, ry, c, s, sx, sy;
		c  = shadow.cos_val;
		s  = shadow.sin_val;
		rx = longint'(r.dst_x) - longint'(shadow.dst_pivot_x);
		ry = longint'(r.dst_y) - longint'(shadow.dst_pivot_y);
		sx = longint'(shadow.org_x) + ((rx * c + ry * s) >>> 16);
		sy = longint'(shadow.org_y) + ((ry * c - rx * s) >>> 16);
		col = int'(sx);
		row = int'(sy);
		return sx >= 0 && sy >= 0
			&& sx < longint'(shadow.used_w) && sy < longint'(shadow.used_h)
			&& sx < SPRITE_SIDE && sy < SPRITE_SIDE;
	endfunction

	// Result beat that one accepted request produces. A load updates the store
	// copy and answers with an all-zero beat, as do misses and transparent texels.
	function automatic res_t blit_result(input req_t r);
		res_t o;
		int col, row;
		logic [31:0] texel;
		o = '0;
		if (r.req_type == REQ_LOAD) begin
			sprite_copy[int'(r.load_row) * SPRITE_SIDE + r.load_col] = r.load_pixel;
		end else if (src_point(r, col, row)) begin
			texel = sprite_copy[row * SPRITE_SIDE + col];
			if (texel != 32'h0) begin
				o.write_enable = 1'b1;
				o.out_x        = r.dst_x;
				o.out_y        = r.dst_y;
				o.out_pixel    = texel;
			end
		end
		return o;
	endfunction

	// Idle cycles before the next beat: often none, otherwise a random draw.
	function automatic int idle_draw(input bit on);
		if (!on || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	// About one texel in six is transparent.
	function automatic logic [31:0] texel_draw();
		return ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom;
	endfunction

	// A destination coordinate scattered around the pivot, kept on the screen.
	function automatic logic [10:0] near_pivot(input int pivot, input int span);
		int v;
		v = pivot + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 2047)
			v = 2047;
		return 11'(v);
	endfunction

	// The fields that a load ignores carry random values.
	task automatic queue_load(input logic [6:0] col, input logic [6:0] row,
			input logic [31:0] pixel);
		req_t r;
		r.req_type   = REQ_LOAD;
		r.load_col   = col;
		r.load_row   = row;
		r.load_pixel = pixel;
		r.dst_x      = 11'($urandom_range(0, 2047));
		r.dst_y      = 11'($urandom_range(0, 2047));
		texel_loaded[int'(row) * SPRITE_SIDE + col] = 1'b1;
		n_loads++;
		req_backlog.push_back(r);
	endtask

	// A pixel that would land on a texel not yet loaded gets a load of that
	// texel queued ahead of it.
	task automatic queue_pixel(input logic [10:0] x, input logic [10:0] y);
		req_t r;
		int col, row;
		r.req_type   = REQ_PIXEL;
		r.load_col   = 7'($urandom_range(0, 127));
		r.load_row   = 7'($urandom_range(0, 127));
		r.load_pixel = $urandom;
		r.dst_x      = x;
		r.dst_y      = y;
		if (src_point(r, col, row) && !texel_loaded[row * SPRITE_SIDE + col])
			queue_load(7'(col), 7'(row), texel_draw());
		n_pixels++;
		req_backlog.push_back(r);
	endtask

	// Programs all eight registers on back-to-back edges. Only called while the
	// pipe is empty, so the shadow copy can follow at the end.
	task automatic apply_setting(input cfg_t s);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SIN_VAL;
		cfg_data  <= CFG_DATA_W'(s.sin_val);
		@(posedge clk);
		cfg_index <= REG_COS_VAL;
		cfg_data  <= CFG_DATA_W'(s.cos_val);
		@(posedge clk);
		cfg_index <= REG_DST_PIVOT_X;
		cfg_data  <= CFG_DATA_W'(s.dst_pivot_x);
		@(posedge clk);
		cfg_index <= REG_DST_PIVOT_Y;
		cfg_data  <= CFG_DATA_W'(s.dst_pivot_y);
		@(posedge clk);
		cfg_index <= REG_ORG_X;
		cfg_data  <= CFG_DATA_W'(s.org_x);
		@(posedge clk);
		cfg_index <= REG_ORG_Y;
		cfg_data  <= CFG_DATA_W'(s.org_y);
		@(posedge clk);
		cfg_index <= REG_USED_W;
		cfg_data  <= CFG_DATA_W'(s.used_w);
		@(posedge clk);
		cfg_index <= REG_USED_H;
		cfg_data  <= CFG_DATA_W'(s.used_h);
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow = s;
		n_settings++;
	endtask

	// Polls on the falling edge, where every rising-edge update has settled.
	// The extra cycles at the end cover the five-stage pipe, so a stray beat
	// would still be caught by the monitor.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || in_valid || due_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s expected %h, got %h", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Request driver. A beat moves when in_valid is high and in_stall low at the
	// edge; that is also when its result is predicted, so store updates and
	// lookups happen in the same order as inside the block. After each beat the
	// driver idles for a drawn number of cycles before offering the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			src_wait <= 0;
		end else begin
			if (in_valid && !in_stall)
				due_results.push_back(blit_result(in_data));
			if (!in_valid || !in_stall) begin
				if (src_wait != 0) begin
					in_valid <= 1'b0;
					src_wait <= src_wait - 1;
				end else if (req_backlog.size() != 0) begin
					in_valid <= 1'b1;
					in_data  <= req_backlog.pop_front();
					src_wait <= idle_draw(src_idle_on);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every taken beat is matched against the oldest prediction,
	// field by field. After each beat the receiver stalls for a drawn number of
	// cycles, which freezes the whole pipe behind it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_wait <= 0;
		end else if (out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$display("%0t ns: result beat with nothing expected, got %p",
					$time, out_data);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (want.write_enable)
					n_writes++;
				check_field("write_enable", 32'(want.write_enable), 32'(out_data.write_enable));
				check_field("out_x", 32'(want.out_x), 32'(out_data.out_x));
				check_field("out_y", 32'(want.out_y), 32'(out_data.out_y));
				check_field("out_pixel", want.out_pixel, out_data.out_pixel);
			end
			next_hold = idle_draw(sink_idle_on);
			sink_wait <= next_hold;
			out_stall <= (next_hold != 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			out_stall <= (sink_wait > 1);
		end
	end

	// A hung handshake ends the run here.
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		cfg_t s;
		int p, n, k, span, lim_w, lim_h;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats under the identity mapping over the full store: the
		// four corners, overwriting a texel, a transparent texel, sources past
		// the used area and the far corners of the screen.
		s = '{sin_val: 0, cos_val: 65536, dst_pivot_x: 0, dst_pivot_y: 0,
			org_x: 0, org_y: 0, used_w: 128, used_h: 128};
		apply_setting(s);
		queue_load(7'd0, 7'd0, 32'hFFFF_FFFF);
		queue_load(7'd127, 7'd127, 32'h0000_0001);
		queue_load(7'd127, 7'd0, 32'h8000_0000);
		queue_load(7'd0, 7'd127, 32'h7FFF_FFFF);
		queue_load(7'd5, 7'd5, 32'h0);
		queue_load(7'd10, 7'd3, 32'h1234_5678);
		queue_pixel(11'd0, 11'd0);
		queue_pixel(11'd127, 11'd127);
		queue_pixel(11'd127, 11'd0);
		queue_pixel(11'd0, 11'd127);
		queue_pixel(11'd5, 11'd5);
		queue_pixel(11'd10, 11'd3);
		queue_pixel(11'd128, 11'd5);
		queue_pixel(11'd5, 11'd128);
		queue_pixel(11'd2047, 11'd2047);
		queue_pixel(11'd2047, 11'd0);
		queue_pixel(11'd0, 11'd2047);
		queue_load(7'd0, 7'd0, 32'h0);
		queue_pixel(11'd0, 11'd0);
		queue_pixel(11'd1, 11'd1);
		wait_idle();

		// Random phases. The first few use fixed settings at the edges of the
		// register ranges: quarter and half turns, the pivot and anchor limits,
		// a one-texel sprite, zero width and height, a used area larger than the
		// store and the largest sine and cosine codes.
		for (p = 1; p <= 13; p++) begin
			case (p)
				1: s = '{sin_val: 65536, cos_val: 0, dst_pivot_x: 1024,
					dst_pivot_y: 1024, org_x: 64, org_y: 64,
					used_w: 128, used_h: 128};
				2: s = '{sin_val: -65536, cos_val: -65536, dst_pivot_x: -2048,
					dst_pivot_y: 4095, org_x: 1023, org_y: -1024,
					used_w: 1, used_h: 1};
				3: s = '{sin_val: 0, cos_val: -65536, dst_pivot_x: 1500,
					dst_pivot_y: 600, org_x: 0, org_y: 0,
					used_w: 128, used_h: 128};
				4: s = '{sin_val: 0, cos_val: 65536, dst_pivot_x: 700,
					dst_pivot_y: 900, org_x: 0, org_y: 0,
					used_w: 0, used_h: 128};
				5: s = '{sin_val: 0, cos_val: 65536, dst_pivot_x: 100,
					dst_pivot_y: 100, org_x: 0, org_y: 0,
					used_w: 200, used_h: 255};
				6: s = '{sin_val: 131071, cos_val: -131072, dst_pivot_x: 800,
					dst_pivot_y: 800, org_x: 64, org_y: 64,
					used_w: 128, used_h: 0};
				7: s = '{sin_val: 0, cos_val: 65536, dst_pivot_x: 300,
					dst_pivot_y: 300, org_x: 0, org_y: 0,
					used_w: 1, used_h: 1};
				default: begin
					// Mostly a sprite placed on screen with its anchor inside,
					// so that many pixels hit; now and then a pivot from a wider range and any anchor.
					s.sin_val = ($urandom_range(0, 7) < 3) ? 18'sd0 :
						18'(int'($urandom_range(0, 131072)) - 65536);
					s.cos_val = ($urandom_range(0, 7) < 3) ? 18'sd65536 :
						18'(int'($urandom_range(0, 131072)) - 65536);
					s.used_w = ($urandom_range(0, 3) == 0) ? 8'd128 :
						8'($urandom_range(1, 128));
					s.used_h = ($urandom_range(0, 3) == 0) ? 8'd128 :
						8'($urandom_range(1, 128));
					if ($urandom_range(0, 7) == 0) begin
						s.dst_pivot_x = 13'(int'($urandom_range(0, 6143)) - 2048);
						s.dst_pivot_y = 13'(int'($urandom_range(0, 6143)) - 2048);
						s.org_x       = 11'(int'($urandom_range(0, 2047)) - 1024);
						s.org_y       = 11'(int'($urandom_range(0, 2047)) - 1024);
					end else begin
						s.dst_pivot_x = 13'($urandom_range(0, 2047));
						s.dst_pivot_y = 13'($urandom_range(0, 2047));
						s.org_x       = 11'($urandom_range(0, s.used_w));
						s.org_y       = 11'($urandom_range(0, s.used_h));
					end
				end
			endcase
			src_idle_on  = (p % 3 != 1);
			sink_idle_on = (p % 4 != 2);
			apply_setting(s);

			// Loads land mostly inside the area that pixels can reach. Most
			// pixels are scattered around the pivot, the rest anywhere.
			lim_w = (shadow.used_w > 128) ? 128 : shadow.used_w;
			lim_h = (shadow.used_h > 128) ? 128 : shadow.used_h;
			span  = ((lim_w > lim_h) ? lim_w : lim_h) + 16;
			for (n = 0; n < 57; n++) begin
				k = $urandom_range(0, 9);
				if (k < 3) begin
					if (k < 2 && lim_w > 0 && lim_h > 0)
						queue_load(7'($urandom_range(0, lim_w - 1)),
							7'($urandom_range(0, lim_h - 1)), texel_draw());
					else
						queue_load(7'($urandom_range(0, 127)),
							7'($urandom_range(0, 127)), $urandom);
				end else if (k < 9) begin
					queue_pixel(near_pivot(shadow.dst_pivot_x, span),
						near_pivot(shadow.dst_pivot_y, span));
				end else begin
					queue_pixel(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
				end
			end
			wait_idle();
		end

		$display("Covered %0d load beats and %0d pixel beats under %0d register settings,",
			n_loads, n_pixels, n_settings);
		$display("of which %0d pixels came out as writes.", n_writes);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== rotated_sprite_blit_affine_core.f =====
+incdir+hdl
hdl/rsb_pkg.sv
hdl/rsb_xform.sv
hdl/rsb_store.sv
hdl/rotated_sprite_blit_affine_core.sv
test/tb.sv
